// ===== hw/rtl/rmq_pkg.sv =====
// Shared widths, stage counts and sideband types for the matrix-to-quaternion pipeline.
package rmq_pkg;

  localparam int FRAC_BITS_DEF = 30;

  localparam int ELEM_W    = 32;
  localparam int ARG_W     = 35;
  localparam int DIFF_W    = 34;
  localparam int RAD_W     = 64;
  localparam int ROOT_W    = 32;
  localparam int SQ_REM_W  = 36;
  localparam int SQ_STAGES = ROOT_W / 2;
  localparam int NUM_W     = 64;
  localparam int DEN_W     = ROOT_W + 1;
  localparam int QUO_W     = 33;
  localparam int DIV_REM_W = DEN_W + 1;
  localparam int DIV_STAGES = QUO_W + 1;
  localparam int LANES     = 3;

  localparam logic [1:0] COMP_W = 2'd0;
  localparam logic [1:0] COMP_X = 2'd1;
  localparam logic [1:0] COMP_Y = 2'd2;
  localparam logic [1:0] COMP_Z = 2'd3;

  typedef struct packed {
    logic signed [DIFF_W-1:0] a;
    logic signed [DIFF_W-1:0] b;
    logic signed [DIFF_W-1:0] c;
    logic [1:0]               idx;
    logic                     degen;
  } side_t;

  typedef struct packed {
    logic [LANES-1:0]  neg;
    logic [1:0]        idx;
    logic              degen;
    logic [ROOT_W-1:0] half;
  } meta_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
    logic [RAD_W-1:0]    rad;
  } sq_t;

  typedef struct packed {
    logic [DIV_REM_W-1:0] rem;
    logic [QUO_W-1:0]     low;
    logic [QUO_W-1:0]     quo;
    logic                 ovf;
  } dv_t;

endpackage

// ===== hw/rtl/rmq_if.sv =====
// Valid/ready channel interfaces for matrix beats in and quaternion beats out.
interface rmq_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] e00;
  logic signed [31:0] e01;
  logic signed [31:0] e02;
  logic signed [31:0] e10;
  logic signed [31:0] e11;
  logic signed [31:0] e12;
  logic signed [31:0] e20;
  logic signed [31:0] e21;
  logic signed [31:0] e22;
  modport source (output valid, e00, e01, e02, e10, e11, e12, e20, e21, e22, input ready);
  modport sink (input valid, e00, e01, e02, e10, e11, e12, e20, e21, e22, output ready);
endinterface

interface rmq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] quat_w;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;
  logic               degenerate;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, degenerate, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, degenerate, output ready);
endinterface

// ===== hw/rtl/rotation_matrix_to_quaternion.sv =====
// Top level: streaming 3x3 rotation matrix to unit quaternion converter.
//
// Usage:
//   in_i carries one matrix per beat (e00..e22, signed fixed point with
//   FRAC_BITS fraction bits); out_o carries one quaternion per beat
//   (quat_w/x/y/z in the same format, plus degenerate).
//   Every input beat yields exactly one output beat, in order.
// Stages: one branch-select stage, 16 square-root stages (two root bits
//   each), one divider setup stage, 34 divider stages (an overflow check,
//   then one quotient bit each), and the output register.
// Throughput: one beat per cycle unless stalled; every stage is registered
//   and a new matrix may enter each cycle that in_i.ready is high.
// Stall: when out_o.ready is low with a result waiting, the whole pipeline
//   holds and in_i.ready drops; no beat is lost or repeated.
// Reset: rst_ni clears all valid bits; the pipeline comes up empty and
//   ready.
// Degenerate root argument: all components are zero and degenerate is set.
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rmq_in_if.sink    in_i,
  rmq_out_if.source out_o
);

  localparam int AW = rmq_pkg::ARG_W;
  localparam int DW = rmq_pkg::DIFF_W;
  localparam int RW = rmq_pkg::ROOT_W;
  localparam int L  = rmq_pkg::LANES;
  localparam int QW = rmq_pkg::QUO_W;
  localparam int SW = $bits(rmq_pkg::side_t);
  localparam int MW = $bits(rmq_pkg::meta_t);
  localparam logic signed [AW-1:0] ONE = AW'(64'sd1 <<< FRAC_BITS);

  logic en;
  logic out_vld_q;

  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // Branch select
  logic signed [AW-1:0] d00, d11, d22, arg_d;
  logic signed [DW-1:0] m01, m02, m10, m12, m20, m21;
  rmq_pkg::side_t       s1_d, s1_q;
  logic signed [AW-1:0] arg_q;
  logic                 s1_vld_q;

  always_comb begin
    d00 = AW'(in_i.e00);
    d11 = AW'(in_i.e11);
    d22 = AW'(in_i.e22);
    m01 = DW'(in_i.e01);
    m02 = DW'(in_i.e02);
    m10 = DW'(in_i.e10);
    m12 = DW'(in_i.e12);
    m20 = DW'(in_i.e20);
    m21 = DW'(in_i.e21);
    s1_d.degen = 1'b0;
    if (d00 + d11 + d22 > 0) begin
      arg_d    = ONE + d00 + d11 + d22;
      s1_d.idx = rmq_pkg::COMP_W;
      s1_d.a   = m12 - m21;
      s1_d.b   = m20 - m02;
      s1_d.c   = m01 - m10;
    end else if ((d00 > d11) && (d00 > d22)) begin
      arg_d    = ONE + d00 - (d11 + d22);
      s1_d.idx = rmq_pkg::COMP_X;
      s1_d.a   = m12 - m21;
      s1_d.b   = m01 + m10;
      s1_d.c   = m02 + m20;
    end else if (!(d00 > d11) && (d11 > d22)) begin
      arg_d    = ONE + d11 - (d22 + d00);
      s1_d.idx = rmq_pkg::COMP_Y;
      s1_d.a   = m20 - m02;
      s1_d.b   = m12 + m21;
      s1_d.c   = m10 + m01;
    end else begin
      arg_d    = ONE + d22 - (d00 + d11);
      s1_d.idx = rmq_pkg::COMP_Z;
      s1_d.a   = m01 - m10;
      s1_d.b   = m20 + m02;
      s1_d.c   = m21 + m12;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q  <= s1_d;
      arg_q <= arg_d;
    end
  end

  // Square root
  rmq_pkg::side_t            sq_in_side, sq_side;
  logic [rmq_pkg::RAD_W-1:0] rad;
  logic [SW-1:0]             sq_side_bits;
  logic [RW-1:0]             sq_root;
  logic                      sq_vld;

  always_comb begin
    sq_in_side       = s1_q;
    sq_in_side.degen = (arg_q <= 0);
    if (sq_in_side.degen) begin
      rad = '0;
    end else begin
      rad = {{(rmq_pkg::RAD_W-AW){1'b0}}, arg_q} << FRAC_BITS;
    end
  end

  rmq_isqrt #(.SW(SW)) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s1_vld_q),
    .rad_i  (rad),
    .side_i (sq_in_side),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side_bits)
  );

  assign sq_side = rmq_pkg::side_t'(sq_side_bits);

  // Divider setup
  logic [rmq_pkg::NUM_W-1:0] num_d [L];
  logic [rmq_pkg::NUM_W-1:0] num_q [L];
  logic [rmq_pkg::DEN_W-1:0] den_q;
  rmq_pkg::meta_t            meta_d, meta_q;
  logic                      su_vld_q;

  always_comb begin
    logic signed [DW-1:0] diff [L];
    logic [DW-1:0]        mag;
    diff[0] = sq_side.a;
    diff[1] = sq_side.b;
    diff[2] = sq_side.c;
    for (int l = 0; l < L; l++) begin
      meta_d.neg[l] = diff[l][DW-1];
      mag      = diff[l][DW-1] ? DW'(-diff[l]) : DW'(diff[l]);
      num_d[l] = ({{(rmq_pkg::NUM_W-DW){1'b0}}, mag} << FRAC_BITS)
                 + {{(rmq_pkg::NUM_W-RW){1'b0}}, sq_root};
    end
    meta_d.idx   = sq_side.idx;
    meta_d.degen = sq_side.degen;
    meta_d.half  = {1'b0, sq_root[RW-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      su_vld_q <= 1'b0;
    end else if (en) begin
      su_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < L; l++) begin
        num_q[l] <= num_d[l];
      end
      den_q  <= {sq_root, 1'b0};
      meta_q <= meta_d;
    end
  end

  // Division
  logic [QW-1:0] quo [L];
  logic          ovf [L];
  logic [MW-1:0] dv_meta_bits;
  rmq_pkg::meta_t dv_meta;
  logic          dv_vld;

  rmq_div3 #(.SW(MW)) u_div3 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (su_vld_q),
    .num_i  (num_q),
    .den_i  (den_q),
    .side_i (meta_q),
    .vld_o  (dv_vld),
    .quo_o  (quo),
    .ovf_o  (ovf),
    .side_o (dv_meta_bits)
  );

  assign dv_meta = rmq_pkg::meta_t'(dv_meta_bits);

  // Saturate, place components, output register
  logic signed [31:0] lane_v [L];
  logic signed [31:0] comp_d [4];
  logic signed [31:0] comp_q [4];
  logic               degen_q;

  always_comb begin
    for (int l = 0; l < L; l++) begin
      if (dv_meta.neg[l]) begin
        if (ovf[l] || quo[l][QW-1] || (quo[l][31] && (quo[l][30:0] != '0))) begin
          lane_v[l] = 32'sh8000_0000;
        end else begin
          lane_v[l] = -$signed(quo[l][31:0]);
        end
      end else begin
        if (ovf[l] || quo[l][QW-1] || quo[l][31]) begin
          lane_v[l] = 32'sh7fff_ffff;
        end else begin
          lane_v[l] = $signed(quo[l][31:0]);
        end
      end
    end
    unique case (dv_meta.idx)
      rmq_pkg::COMP_W: begin
        comp_d[rmq_pkg::COMP_W] = $signed(dv_meta.half);
        comp_d[rmq_pkg::COMP_X] = lane_v[0];
        comp_d[rmq_pkg::COMP_Y] = lane_v[1];
        comp_d[rmq_pkg::COMP_Z] = lane_v[2];
      end
      rmq_pkg::COMP_X: begin
        comp_d[rmq_pkg::COMP_X] = $signed(dv_meta.half);
        comp_d[rmq_pkg::COMP_W] = lane_v[0];
        comp_d[rmq_pkg::COMP_Y] = lane_v[1];
        comp_d[rmq_pkg::COMP_Z] = lane_v[2];
      end
      rmq_pkg::COMP_Y: begin
        comp_d[rmq_pkg::COMP_Y] = $signed(dv_meta.half);
        comp_d[rmq_pkg::COMP_W] = lane_v[0];
        comp_d[rmq_pkg::COMP_Z] = lane_v[1];
        comp_d[rmq_pkg::COMP_X] = lane_v[2];
      end
      default: begin
        comp_d[rmq_pkg::COMP_Z] = $signed(dv_meta.half);
        comp_d[rmq_pkg::COMP_W] = lane_v[0];
        comp_d[rmq_pkg::COMP_X] = lane_v[1];
        comp_d[rmq_pkg::COMP_Y] = lane_v[2];
      end
    endcase
    if (dv_meta.degen) begin
      for (int i = 0; i < 4; i++) begin
        comp_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        comp_q[i] <= comp_d[i];
      end
      degen_q <= dv_meta.degen;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.quat_w     = comp_q[0];
  assign out_o.quat_x     = comp_q[1];
  assign out_o.quat_y     = comp_q[2];
  assign out_o.quat_z     = comp_q[3];
  assign out_o.degenerate = degen_q;

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.degenerate) |-> (out_o.quat_w == 0 && out_o.quat_x == 0
      && out_o.quat_y == 0 && out_o.quat_z == 0))
    else $error("degenerate result with nonzero component");
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while output stalled");
  a_root_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_vld && !sq_side.degen) |-> (sq_root != '0))
    else $error("zero root on a valid argument");
  a_trace_not_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && s1_q.idx == rmq_pkg::COMP_W) |-> (arg_q > 0))
    else $error("trace branch with non-positive argument");
`endif

endmodule

// ===== hw/rtl/rmq_isqrt.sv =====
// Pipelined integer square root, two result bits per stage, with a sideband.
module rmq_isqrt #(
  parameter int SW = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  logic [rmq_pkg::RAD_W-1:0]  rad_i,
  input  logic [SW-1:0]              side_i,
  output logic                       vld_o,
  output logic [rmq_pkg::ROOT_W-1:0] root_o,
  output logic [SW-1:0]              side_o
);

  localparam int N = rmq_pkg::SQ_STAGES;

  rmq_pkg::sq_t  st_q   [N];
  logic          vld_q  [N];
  logic [SW-1:0] side_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    rmq_pkg::sq_t  src;
    rmq_pkg::sq_t  st_d;
    logic          src_vld;
    logic [SW-1:0] src_side;

    if (k == 0) begin : g_first
      assign src      = '{rem: '0, root: '0, rad: rad_i};
      assign src_vld  = vld_i;
      assign src_side = side_i;
    end else begin : g_rest
      assign src      = st_q[k-1];
      assign src_vld  = vld_q[k-1];
      assign src_side = side_q[k-1];
    end

    always_comb begin
      logic [rmq_pkg::SQ_REM_W-1:0] r2;
      logic [rmq_pkg::SQ_REM_W-1:0] trial;
      st_d = src;
      for (int j = 0; j < 2; j++) begin
        r2    = {st_d.rem[rmq_pkg::SQ_REM_W-3:0], st_d.rad[rmq_pkg::RAD_W-1 -: 2]};
        trial = {2'b00, st_d.root, 2'b01};
        if (r2 >= trial) begin
          st_d.rem  = r2 - trial;
          st_d.root = {st_d.root[rmq_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          st_d.rem  = r2;
          st_d.root = {st_d.root[rmq_pkg::ROOT_W-2:0], 1'b0};
        end
        st_d.rad = {st_d.rad[rmq_pkg::RAD_W-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k]   <= st_d;
        side_q[k] <= src_side;
      end
    end
  end

  assign vld_o  = vld_q[N-1];
  assign root_o = st_q[N-1].root;
  assign side_o = side_q[N-1];

endmodule

// ===== hw/rtl/rmq_div3.sv =====
// Restoring divider pipe, 3 lanes, 1 shared divisor: overflow stage, then a quotient bit each.
module rmq_div3 #(
  parameter int SW = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  logic [rmq_pkg::NUM_W-1:0] num_i [rmq_pkg::LANES],
  input  logic [rmq_pkg::DEN_W-1:0] den_i,
  input  logic [SW-1:0]             side_i,
  output logic                      vld_o,
  output logic [rmq_pkg::QUO_W-1:0] quo_o [rmq_pkg::LANES],
  output logic                      ovf_o [rmq_pkg::LANES],
  output logic [SW-1:0]             side_o
);

  localparam int N  = rmq_pkg::DIV_STAGES;
  localparam int L  = rmq_pkg::LANES;
  localparam int QW = rmq_pkg::QUO_W;
  localparam int RW = rmq_pkg::DIV_REM_W;
  localparam int HW = rmq_pkg::NUM_W - QW;

  rmq_pkg::dv_t             st_q  [N][L];
  logic [rmq_pkg::DEN_W-1:0] den_q [N];
  logic                     vld_q [N];
  logic [SW-1:0]            side_q[N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    rmq_pkg::dv_t              st_d [L];
    logic [rmq_pkg::DEN_W-1:0] src_den;
    logic                      src_vld;
    logic [SW-1:0]             src_side;

    if (k == 0) begin : g_first
      assign src_den  = den_i;
      assign src_vld  = vld_i;
      assign src_side = side_i;
      always_comb begin
        for (int l = 0; l < L; l++) begin
          st_d[l].ovf = {{(RW-HW){1'b0}}, num_i[l][rmq_pkg::NUM_W-1 -: HW]}
                        >= {1'b0, den_i};
          st_d[l].rem = {{(RW-HW){1'b0}}, num_i[l][rmq_pkg::NUM_W-1 -: HW]};
          st_d[l].low = num_i[l][QW-1:0];
          st_d[l].quo = '0;
        end
      end
    end else begin : g_rest
      assign src_den  = den_q[k-1];
      assign src_vld  = vld_q[k-1];
      assign src_side = side_q[k-1];
      always_comb begin
        logic [RW-1:0] r2;
        r2 = '0;
        for (int l = 0; l < L; l++) begin
          st_d[l] = st_q[k-1][l];
          r2 = {st_d[l].rem[RW-2:0], st_d[l].low[QW-1]};
          if (r2 >= {1'b0, src_den}) begin
            st_d[l].rem = r2 - {1'b0, src_den};
            st_d[l].quo = {st_d[l].quo[QW-2:0], 1'b1};
          end else begin
            st_d[l].rem = r2;
            st_d[l].quo = {st_d[l].quo[QW-2:0], 1'b0};
          end
          st_d[l].low = {st_d[l].low[QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < L; l++) begin
          st_q[k][l] <= st_d[l];
        end
        den_q[k]  <= src_den;
        side_q[k] <= src_side;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < L; l++) begin
      quo_o[l] = st_q[N-1][l].quo;
      ovf_o[l] = st_q[N-1][l].ovf;
    end
  end

  assign vld_o  = vld_q[N-1];
  assign side_o = side_q[N-1];

endmodule
